FILE: hdl/lebh_pkg.sv
// ----------------------------------------------------------------------------
// lebh_pkg
// Shared constants, codes and types of the line edit buffer with history.
// ----------------------------------------------------------------------------
package lebh_pkg;

   localparam int LINE_CAP_DEF   = 64;
   localparam int HIST_DEPTH_DEF = 64;

   localparam int LEN_W     = 7;
   localparam int CMD_W     = 4;
   localparam int CHAR_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [LEN_W-1:0] HIST_LIMIT_RST = 7'd50;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_LIMIT = 1'b1;

   localparam logic [CMD_W-1:0] CMD_INSERT = 4'd0;
   localparam logic [CMD_W-1:0] CMD_RIGHT  = 4'd1;
   localparam logic [CMD_W-1:0] CMD_LEFT   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_HOME   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_END    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_NWORD  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_PWORD  = 4'd6;
   localparam logic [CMD_W-1:0] CMD_BKSP   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_DEL    = 4'd8;
   localparam logic [CMD_W-1:0] CMD_CLREOL = 4'd9;
   localparam logic [CMD_W-1:0] CMD_TOGGLE = 4'd10;
   localparam logic [CMD_W-1:0] CMD_UP     = 4'd11;
   localparam logic [CMD_W-1:0] CMD_DOWN   = 4'd12;
   localparam logic [CMD_W-1:0] CMD_ENTER  = 4'd13;
   localparam logic [CMD_W-1:0] CMD_ABORT  = 4'd14;
   localparam logic [CMD_W-1:0] CMD_NONE   = 4'd15;

   localparam logic [STATUS_W-1:0] STS_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STS_REJECT = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NOEFF  = 2'd2;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STP_NONE   = 4'd0;
   localparam logic [STEP_W-1:0] STP_ACCEPT = 4'd1;
   localparam logic [STEP_W-1:0] STP_EXEC   = 4'd2;
   localparam logic [STEP_W-1:0] STP_SH_RD  = 4'd3;
   localparam logic [STEP_W-1:0] STP_SH_WR  = 4'd4;
   localparam logic [STEP_W-1:0] STP_INS_WR = 4'd5;
   localparam logic [STEP_W-1:0] STP_SC_RD  = 4'd6;
   localparam logic [STEP_W-1:0] STP_SC_EV  = 4'd7;
   localparam logic [STEP_W-1:0] STP_HL_RD  = 4'd8;
   localparam logic [STEP_W-1:0] STP_HL_LD  = 4'd9;
   localparam logic [STEP_W-1:0] STP_HC_RD  = 4'd10;
   localparam logic [STEP_W-1:0] STP_HC_WR  = 4'd11;
   localparam logic [STEP_W-1:0] STP_EN_RD  = 4'd12;
   localparam logic [STEP_W-1:0] STP_EN_OUT = 4'd13;
   localparam logic [STEP_W-1:0] STP_EN_FIN = 4'd14;
   localparam logic [STEP_W-1:0] STP_EMIT   = 4'd15;

   typedef struct packed {
      logic [STEP_W-1:0] step;
   } ctl_type;

   typedef struct packed {
      logic rej;
      logic ovwr;
      logic hist_ok;
      logic hist_clear;
      logic len_zero;
      logic shift_more;
      logic scan_done;
      logic copy_more;
      logic en_last;
      logic out_free;
   } stat_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

endpackage

FILE: hdl/lebh_ram.sv
// ----------------------------------------------------------------------------
// lebh_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module lebh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lebh_dp.sv
// ----------------------------------------------------------------------------
// lebh_dp
// Datapath: line and history stores, cursor and length, history pointers,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module lebh_dp #(
   parameter int LINE_CAP   = lebh_pkg::LINE_CAP_DEF,
   parameter int HIST_DEPTH = lebh_pkg::HIST_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lebh_pkg::ctl_type             ctl,
   output lebh_pkg::stat_type            stat,
   input  logic [lebh_pkg::CMD_W-1:0]    req_cmd,
   input  logic [lebh_pkg::CHAR_W-1:0]   req_char_in,
   input  logic                          csr_write_en,
   input  logic [lebh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lebh_pkg::LEN_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lebh_pkg::LEN_W-1:0]    rsp_cursor_pos,
   output logic [lebh_pkg::LEN_W-1:0]    rsp_line_length,
   output logic                          rsp_overwrite_on,
   output logic [lebh_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_char_valid,
   output logic [lebh_pkg::CHAR_W-1:0]   rsp_char_out,
   output logic                          rsp_line_done,
   output logic                          rsp_last
);
   import lebh_pkg::*;

   localparam int LW  = $clog2(LINE_CAP + 1);
   localparam int AW  = $clog2(LINE_CAP);
   localparam int SW  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int CW  = $clog2(HIST_DEPTH + 1);
   localparam int HAW = $clog2(HIST_DEPTH * LINE_CAP);

   localparam logic [2:0] PH_NW1 = 3'd0;
   localparam logic [2:0] PH_NW2 = 3'd1;
   localparam logic [2:0] PH_PW1 = 3'd2;
   localparam logic [2:0] PH_PW2 = 3'd3;
   localparam logic [2:0] PH_PW3 = 3'd4;
   localparam logic [2:0] PH_PW4 = 3'd5;

   function automatic logic [SW-1:0] wrap(input logic [CW:0] v);
      if (v >= (CW+1)'(HIST_DEPTH)) begin
         return SW'(v - (CW+1)'(HIST_DEPTH));
      end
      return SW'(v);
   endfunction

   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [LW-1:0]     cur_ff, cur_in, len_ff, len_in, p0_ff, p0_in, l0_ff, l0_in;
   logic [LW-1:0]     idx_ff, idx_in;
   logic              mode_ff, mode_in;
   logic [2:0]        phase_ff, phase_in;
   logic              rej_ff, rej_in, noeff_ff, noeff_in;
   logic              hok_ff, hok_in, hclr_ff, hclr_in, push_ff, push_in;
   logic [SW-1:0]     oldest_ff, oldest_in, slot_ff, slot_in;
   logic [CW-1:0]     count_ff, count_in, bp_ff, bp_in;
   logic              browsing_ff, browsing_in;
   logic [LEN_W-1:0]  maxlen_ff, maxlen_in, hlim_ff, hlim_in;

   logic                rv_ff, rv_in;
   logic [LEN_W-1:0]    rcur_ff, rcur_in, rlen_ff, rlen_in;
   logic                rmode_ff, rmode_in;
   logic [STATUS_W-1:0] rsts_ff, rsts_in;
   logic                rcv_ff, rcv_in;
   logic [CHAR_W-1:0]   rch_ff, rch_in;
   logic                rdone_ff, rdone_in, rlast_ff, rlast_in;

   logic              lw_en, lr_en;
   logic [AW-1:0]     lw_addr, lr_addr;
   logic [CHAR_W-1:0] lw_data, lr_data;
   logic              hcw_en, hcr_en;
   logic [HAW-1:0]    hc_addr;
   logic [CHAR_W-1:0] hcr_data;
   logic              hlw_en, hlr_en;
   logic [LEN_W-1:0]  hlr_data, hl_len;

   logic [LEN_W:0]    lim;
   logic              ins_ok, up_ok, dn_ok, sp, out_free;
   logic [CW-1:0]     cap, nb_up, nb_dn;
   logic [SW-1:0]     slot_up, slot_dn, old_nx, slot_new, slot_full;
   logic [STATUS_W-1:0] emit_sts;

   assign lim = ((maxlen_ff == '0) || (maxlen_ff > LEN_W'(LINE_CAP)))
                ? (LEN_W+1)'(LINE_CAP) : {1'b0, maxlen_ff};
   assign ins_ok = mode_ff ? ((LEN_W+1)'(cur_ff) + 1'b1 <= lim)
                           : ((LEN_W+1)'(len_ff) + 1'b1 <= lim);
   assign cap = (hlim_ff > LEN_W'(HIST_DEPTH)) ? CW'(HIST_DEPTH) : CW'(hlim_ff);
   assign up_ok = (count_ff != '0) && !(browsing_ff && (bp_ff == '0));
   assign dn_ok = (count_ff != '0) && browsing_ff;
   assign nb_up = browsing_ff ? bp_ff - 1'b1 : count_ff - 1'b1;
   assign nb_dn = bp_ff + 1'b1;
   assign slot_up = wrap((CW+1)'(oldest_ff) + (CW+1)'(nb_up));
   assign slot_dn = wrap((CW+1)'(oldest_ff) + (CW+1)'(nb_dn));
   assign old_nx = wrap((CW+1)'(oldest_ff) + 1'b1);
   assign slot_new = wrap((CW+1)'(oldest_ff) + (CW+1)'(count_ff));
   assign slot_full = wrap((CW+1)'(old_nx) + (CW+1)'(count_ff) - 1'b1);
   assign sp = (idx_ff < len_ff) && is_space(lr_data);
   assign out_free = !rv_ff || !rsp_stall;
   assign hl_len = (hlr_data > LEN_W'(LINE_CAP)) ? LEN_W'(LINE_CAP) : hlr_data;
   assign hc_addr = HAW'(slot_ff) * HAW'(LINE_CAP) + HAW'(idx_ff);

   always_comb begin
      if ((cmd_ff == CMD_TOGGLE) || (cmd_ff == CMD_ENTER) || (cmd_ff == CMD_ABORT)) begin
         emit_sts = STS_DONE;
      end else if (rej_ff) begin
         emit_sts = STS_REJECT;
      end else if (noeff_ff) begin
         emit_sts = STS_NOEFF;
      end else if ((cmd_ff <= CMD_CLREOL) && (cur_ff == p0_ff) && (len_ff == l0_ff)) begin
         emit_sts = STS_NOEFF;
      end else begin
         emit_sts = STS_DONE;
      end
   end

   always_comb begin
      stat.rej        = rej_ff;
      stat.ovwr       = mode_ff;
      stat.hist_ok    = hok_ff;
      stat.hist_clear = hclr_ff;
      stat.len_zero   = (len_ff == '0);
      stat.shift_more = (cmd_ff == CMD_INSERT) ? (idx_ff > cur_ff) : (idx_ff < len_ff);
      stat.copy_more  = (idx_ff < len_ff);
      stat.en_last    = (idx_ff + 1'b1 == len_ff);
      stat.out_free   = out_free;
      stat.scan_done  = ((phase_ff == PH_NW2) || (phase_ff == PH_PW4)) && !sp;
   end

   always_comb begin
      cmd_in = cmd_ff;  ch_in = ch_ff;  cur_in = cur_ff;  len_in = len_ff;
      p0_in = p0_ff;  l0_in = l0_ff;  idx_in = idx_ff;  mode_in = mode_ff;
      phase_in = phase_ff;  rej_in = rej_ff;  noeff_in = noeff_ff;
      hok_in = hok_ff;  hclr_in = hclr_ff;  push_in = push_ff;
      oldest_in = oldest_ff;  slot_in = slot_ff;  count_in = count_ff;
      bp_in = bp_ff;  browsing_in = browsing_ff;
      maxlen_in = maxlen_ff;  hlim_in = hlim_ff;
      rv_in = rv_ff && rsp_stall;
      rcur_in = rcur_ff;  rlen_in = rlen_ff;  rmode_in = rmode_ff;  rsts_in = rsts_ff;
      rcv_in = rcv_ff;  rch_in = rch_ff;  rdone_in = rdone_ff;  rlast_in = rlast_ff;
      lw_en = 1'b0;  lw_addr = AW'(cur_ff);  lw_data = ch_ff;
      lr_en = 1'b0;  lr_addr = AW'(idx_ff);
      hcw_en = 1'b0;  hcr_en = 1'b0;  hlw_en = 1'b0;  hlr_en = 1'b0;

      if (csr_write_en) begin
         if (csr_index == CSR_MAX_LENGTH) begin
            maxlen_in = csr_wdata;
         end else begin
            hlim_in = csr_wdata;
         end
      end

      unique case (ctl.step)
         STP_ACCEPT: begin
            cmd_in = req_cmd;
            ch_in = req_char_in;
            p0_in = cur_ff;
            l0_in = len_ff;
            rej_in = (req_cmd == CMD_INSERT) && !ins_ok;
            hok_in = (req_cmd == CMD_UP) ? up_ok : dn_ok;
            hclr_in = ((CW+1)'(bp_ff) + 1'b1) >= (CW+1)'(count_ff);
            noeff_in = ((req_cmd == CMD_UP) && !up_ok) || ((req_cmd == CMD_DOWN) && !dn_ok)
                       || (req_cmd == CMD_NONE);
            phase_in = (req_cmd == CMD_NWORD) ? PH_NW1 : PH_PW1;
            if (req_cmd == CMD_INSERT) begin
               idx_in = len_ff;
            end else if (req_cmd == CMD_ENTER) begin
               idx_in = '0;
            end else begin
               idx_in = cur_ff;
            end
         end
         STP_EXEC: begin
            unique case (cmd_ff)
               CMD_INSERT: begin
                  if (!rej_ff && mode_ff) begin
                     lw_en = 1'b1;
                     if (cur_ff + 1'b1 > len_ff) begin
                        len_in = cur_ff + 1'b1;
                     end
                     cur_in = cur_ff + 1'b1;
                  end
               end
               CMD_RIGHT: begin
                  if (cur_ff < len_ff) begin
                     cur_in = cur_ff + 1'b1;
                  end
               end
               CMD_LEFT: begin
                  if (cur_ff != '0) begin
                     cur_in = cur_ff - 1'b1;
                  end
               end
               CMD_HOME: cur_in = '0;
               CMD_END: cur_in = len_ff;
               CMD_BKSP: begin
                  if (cur_ff != '0) begin
                     cur_in = cur_ff - 1'b1;
                     len_in = len_ff - 1'b1;
                     idx_in = cur_ff - 1'b1;
                  end else begin
                     idx_in = len_ff;
                  end
               end
               CMD_DEL: begin
                  if (cur_ff < len_ff) begin
                     len_in = len_ff - 1'b1;
                     idx_in = cur_ff;
                  end else begin
                     idx_in = len_ff;
                  end
               end
               CMD_CLREOL: len_in = cur_ff;
               CMD_TOGGLE: mode_in = !mode_ff;
               CMD_UP: begin
                  if (hok_ff) begin
                     bp_in = nb_up;
                     browsing_in = 1'b1;
                     slot_in = slot_up;
                     idx_in = '0;
                  end
               end
               CMD_DOWN: begin
                  if (hok_ff) begin
                     if (hclr_ff) begin
                        browsing_in = 1'b0;
                        bp_in = '0;
                        len_in = '0;
                        cur_in = '0;
                     end else begin
                        bp_in = nb_dn;
                        slot_in = slot_dn;
                        idx_in = '0;
                     end
                  end
               end
               CMD_ENTER: begin
                  push_in = (cap != '0) && (len_ff != '0);
                  if ((cap != '0) && (len_ff != '0)) begin
                     if (count_ff < cap) begin
                        slot_in = slot_new;
                        count_in = count_ff + 1'b1;
                     end else begin
                        oldest_in = old_nx;
                        slot_in = slot_full;
                     end
                  end
               end
               CMD_ABORT: begin
                  len_in = '0;
                  cur_in = '0;
                  browsing_in = 1'b0;
                  bp_in = '0;
               end
               default: begin
               end
            endcase
         end
         STP_SH_RD: begin
            lr_en = 1'b1;
            lr_addr = (cmd_ff == CMD_INSERT) ? AW'(idx_ff - 1'b1) : AW'(idx_ff + 1'b1);
         end
         STP_SH_WR: begin
            lw_en = 1'b1;
            lw_addr = AW'(idx_ff);
            lw_data = lr_data;
            idx_in = (cmd_ff == CMD_INSERT) ? idx_ff - 1'b1 : idx_ff + 1'b1;
         end
         STP_INS_WR: begin
            lw_en = 1'b1;
            len_in = len_ff + 1'b1;
            cur_in = cur_ff + 1'b1;
         end
         STP_SC_RD: lr_en = 1'b1;
         STP_SC_EV: begin
            unique case (phase_ff)
               PH_NW1: begin
                  if ((idx_ff < len_ff) && !sp) idx_in = idx_ff + 1'b1;
                  else phase_in = PH_NW2;
               end
               PH_NW2: begin
                  if (sp) idx_in = idx_ff + 1'b1;
                  else cur_in = idx_ff;
               end
               PH_PW1: begin
                  if ((idx_ff != '0) && !sp) idx_in = idx_ff - 1'b1;
                  else phase_in = PH_PW2;
               end
               PH_PW2: begin
                  if ((idx_ff != '0) && sp) idx_in = idx_ff - 1'b1;
                  else phase_in = PH_PW3;
               end
               PH_PW3: begin
                  if ((idx_ff != '0) && !sp) idx_in = idx_ff - 1'b1;
                  else phase_in = PH_PW4;
               end
               default: begin
                  if (sp) idx_in = idx_ff + 1'b1;
                  else cur_in = idx_ff;
               end
            endcase
         end
         STP_HL_RD: hlr_en = 1'b1;
         STP_HL_LD: begin
            len_in = LW'(hl_len);
            cur_in = LW'(hl_len);
         end
         STP_HC_RD: hcr_en = 1'b1;
         STP_HC_WR: begin
            lw_en = 1'b1;
            lw_addr = AW'(idx_ff);
            lw_data = hcr_data;
            idx_in = idx_ff + 1'b1;
         end
         STP_EN_RD: lr_en = 1'b1;
         STP_EN_OUT: begin
            hcw_en = push_ff;
            idx_in = idx_ff + 1'b1;
            rv_in = 1'b1;
            rcur_in = '0;
            rlen_in = '0;
            rmode_in = mode_ff;
            rsts_in = STS_DONE;
            rcv_in = 1'b1;
            rch_in = lr_data;
            rdone_in = stat.en_last;
            rlast_in = stat.en_last;
         end
         STP_EN_FIN: begin
            hlw_en = push_ff;
            len_in = '0;
            cur_in = '0;
            browsing_in = 1'b0;
            bp_in = '0;
         end
         STP_EMIT: begin
            rv_in = 1'b1;
            rcur_in = LEN_W'(cur_ff);
            rlen_in = LEN_W'(len_ff);
            rmode_in = mode_ff;
            rsts_in = emit_sts;
            rcv_in = 1'b0;
            rch_in = '0;
            rdone_in = (cmd_ff == CMD_ENTER) || (cmd_ff == CMD_ABORT);
            rlast_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         len_ff <= '0;
         mode_ff <= 1'b0;
         oldest_ff <= '0;
         count_ff <= '0;
         bp_ff <= '0;
         browsing_ff <= 1'b0;
         maxlen_ff <= '0;
         hlim_ff <= HIST_LIMIT_RST;
         rv_ff <= 1'b0;
      end else begin
         cur_ff <= cur_in;
         len_ff <= len_in;
         mode_ff <= mode_in;
         oldest_ff <= oldest_in;
         count_ff <= count_in;
         bp_ff <= bp_in;
         browsing_ff <= browsing_in;
         maxlen_ff <= maxlen_in;
         hlim_ff <= hlim_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      ch_ff <= ch_in;
      p0_ff <= p0_in;
      l0_ff <= l0_in;
      idx_ff <= idx_in;
      phase_ff <= phase_in;
      rej_ff <= rej_in;
      noeff_ff <= noeff_in;
      hok_ff <= hok_in;
      hclr_ff <= hclr_in;
      push_ff <= push_in;
      slot_ff <= slot_in;
      rcur_ff <= rcur_in;
      rlen_ff <= rlen_in;
      rmode_ff <= rmode_in;
      rsts_ff <= rsts_in;
      rcv_ff <= rcv_in;
      rch_ff <= rch_in;
      rdone_ff <= rdone_in;
      rlast_ff <= rlast_in;
   end

   lebh_ram #(.WIDTH(CHAR_W), .DEPTH(LINE_CAP), .AW(AW)) u_line (
      .clock   (clock),
      .wr_en   (lw_en),
      .wr_addr (lw_addr),
      .wr_data (lw_data),
      .rd_en   (lr_en),
      .rd_addr (lr_addr),
      .rd_data (lr_data)
   );

   lebh_ram #(.WIDTH(CHAR_W), .DEPTH(HIST_DEPTH * LINE_CAP), .AW(HAW)) u_hchars (
      .clock   (clock),
      .wr_en   (hcw_en),
      .wr_addr (hc_addr),
      .wr_data (lr_data),
      .rd_en   (hcr_en),
      .rd_addr (hc_addr),
      .rd_data (hcr_data)
   );

   lebh_ram #(.WIDTH(LEN_W), .DEPTH(HIST_DEPTH), .AW(SW)) u_hlens (
      .clock   (clock),
      .wr_en   (hlw_en),
      .wr_addr (slot_ff),
      .wr_data (LEN_W'(len_ff)),
      .rd_en   (hlr_en),
      .rd_addr (slot_ff),
      .rd_data (hlr_data)
   );

   assign rsp_valid        = rv_ff;
   assign rsp_cursor_pos   = rcur_ff;
   assign rsp_line_length  = rlen_ff;
   assign rsp_overwrite_on = rmode_ff;
   assign rsp_status       = rsts_ff;
   assign rsp_char_valid   = rcv_ff;
   assign rsp_char_out     = rch_ff;
   assign rsp_line_done    = rdone_ff;
   assign rsp_last         = rlast_ff;

endmodule

FILE: hdl/lebh_ctrl.sv
// ----------------------------------------------------------------------------
// lebh_ctrl
// Controller: sequences the datapath steps of each edit command.
// ----------------------------------------------------------------------------
module lebh_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [lebh_pkg::CMD_W-1:0] req_cmd,
   output logic                       req_stall,
   output lebh_pkg::ctl_type          ctl,
   input  lebh_pkg::stat_type         stat
);
   import lebh_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DISP    = 4'd1;
   localparam logic [3:0] S_SH_RD   = 4'd2;
   localparam logic [3:0] S_SH_WR   = 4'd3;
   localparam logic [3:0] S_SC_RD   = 4'd4;
   localparam logic [3:0] S_SC_EV   = 4'd5;
   localparam logic [3:0] S_HL_RD   = 4'd6;
   localparam logic [3:0] S_HL_LD   = 4'd7;
   localparam logic [3:0] S_HC_RD   = 4'd8;
   localparam logic [3:0] S_HC_WR   = 4'd9;
   localparam logic [3:0] S_EN_RD   = 4'd10;
   localparam logic [3:0] S_EN_OUT  = 4'd11;
   localparam logic [3:0] S_EN_FIN  = 4'd12;
   localparam logic [3:0] S_EN_FIN0 = 4'd13;
   localparam logic [3:0] S_EMIT    = 4'd14;

   logic [3:0]       state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      ctl.step = STP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.step = STP_ACCEPT;
               cmd_in = req_cmd;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            ctl.step = STP_EXEC;
            unique case (cmd_ff)
               CMD_INSERT: state_in = (stat.rej || stat.ovwr) ? S_EMIT : S_SH_RD;
               CMD_BKSP, CMD_DEL: state_in = S_SH_RD;
               CMD_NWORD, CMD_PWORD: state_in = S_SC_RD;
               CMD_UP: state_in = stat.hist_ok ? S_HL_RD : S_EMIT;
               CMD_DOWN: state_in = (stat.hist_ok && !stat.hist_clear) ? S_HL_RD : S_EMIT;
               CMD_ENTER: state_in = stat.len_zero ? S_EN_FIN0 : S_EN_RD;
               default: state_in = S_EMIT;
            endcase
         end
         S_SH_RD: begin
            if (stat.shift_more) begin
               ctl.step = STP_SH_RD;
               state_in = S_SH_WR;
            end else begin
               if (cmd_ff == CMD_INSERT) begin
                  ctl.step = STP_INS_WR;
               end
               state_in = S_EMIT;
            end
         end
         S_SH_WR: begin
            ctl.step = STP_SH_WR;
            state_in = S_SH_RD;
         end
         S_SC_RD: begin
            ctl.step = STP_SC_RD;
            state_in = S_SC_EV;
         end
         S_SC_EV: begin
            ctl.step = STP_SC_EV;
            state_in = stat.scan_done ? S_EMIT : S_SC_RD;
         end
         S_HL_RD: begin
            ctl.step = STP_HL_RD;
            state_in = S_HL_LD;
         end
         S_HL_LD: begin
            ctl.step = STP_HL_LD;
            state_in = S_HC_RD;
         end
         S_HC_RD: begin
            if (stat.copy_more) begin
               ctl.step = STP_HC_RD;
               state_in = S_HC_WR;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_HC_WR: begin
            ctl.step = STP_HC_WR;
            state_in = S_HC_RD;
         end
         S_EN_RD: begin
            ctl.step = STP_EN_RD;
            state_in = S_EN_OUT;
         end
         S_EN_OUT: begin
            if (stat.out_free) begin
               ctl.step = STP_EN_OUT;
               state_in = stat.en_last ? S_EN_FIN : S_EN_RD;
            end
         end
         S_EN_FIN: begin
            ctl.step = STP_EN_FIN;
            state_in = S_IDLE;
         end
         S_EN_FIN0: begin
            ctl.step = STP_EN_FIN;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               ctl.step = STP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

FILE: hdl/line_edit_buffer_with_history.sv
// ----------------------------------------------------------------------------
// line_edit_buffer_with_history
// Line editor with cursor, insert/overwrite mode and a ring of past lines.
// ----------------------------------------------------------------------------
// usage
//   req channel carries one decoded edit command and a character per transfer
//   rsp channel returns one result per command, or one per character on enter
//   csr port writes max_length (index 0) and history_limit (index 1); writing only while idle is up to the user
// command sequencing
//   one command at a time; req_stall is high from the transfer until the
//   command ends, which for a non-empty enter is after the S_EN_FIN state that follows its last result
//   simple moves, toggle, abort, overwrite typing and idle history steps go from S_DISP to S_EMIT
//   insert, backspace and delete: S_SH_RD and S_SH_WR per shifted character
//   word moves: S_SC_RD and S_SC_EV per scan step (one position read each)
//   history up/down that loads a line: S_HL_RD, S_HL_LD, then S_HC_RD and S_HC_WR per copied character
//   enter: S_EN_RD and S_EN_OUT per character, then S_EN_FIN (S_EN_FIN0 when the line is empty)
// reset
//   empty line, insert mode, empty history, max_length 0, history_limit 50
// stall
//   a stalled result holds in the output register; the sequencer waits for it
// ----------------------------------------------------------------------------
module line_edit_buffer_with_history #(
   parameter int LINE_CAP   = lebh_pkg::LINE_CAP_DEF,
   parameter int HIST_DEPTH = lebh_pkg::HIST_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lebh_pkg::CMD_W-1:0]     req_cmd,
   input  logic [lebh_pkg::CHAR_W-1:0]    req_char_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lebh_pkg::LEN_W-1:0]     rsp_cursor_pos,
   output logic [lebh_pkg::LEN_W-1:0]     rsp_line_length,
   output logic                           rsp_overwrite_on,
   output logic [lebh_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_char_valid,
   output logic [lebh_pkg::CHAR_W-1:0]    rsp_char_out,
   output logic                           rsp_line_done,
   output logic                           rsp_last,
   input  logic                           csr_write_en,
   input  logic [lebh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lebh_pkg::LEN_W-1:0]     csr_wdata
);
   import lebh_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   lebh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .ctl       (ctl),
      .stat      (stat)
   );

   lebh_dp #(.LINE_CAP(LINE_CAP), .HIST_DEPTH(HIST_DEPTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_char_in      (req_char_in),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_line_length  (rsp_line_length),
      .rsp_overwrite_on (rsp_overwrite_on),
      .rsp_status       (rsp_status),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_char_out     (rsp_char_out),
      .rsp_line_done    (rsp_line_done),
      .rsp_last         (rsp_last)
   );

endmodule
